[src/assert_macros.svh]
// Assertion macros used by the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/ssq_pkg.sv]
// Types and constants of the stable sorted priority queue.
package ssq_pkg;

  localparam int unsigned KEY_W      = 31;
  localparam int unsigned BOARD_W    = 36;
  localparam int unsigned COST_W     = 31;
  localparam int unsigned PARENT_W   = 16;
  localparam int unsigned OCC_W      = 7;
  localparam int unsigned ENTRY_W    = KEY_W + BOARD_W + COST_W + PARENT_W;
  localparam int unsigned IN_TDATA_W  = ((ENTRY_W + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = ((ENTRY_W + OCC_W + 7) / 8) * 8;
  localparam int unsigned OUT_TUSER_W = 2;

  localparam int unsigned DEF_QUEUE_DEPTH = 64;

  localparam logic [KEY_W-1:0]  EMPTY_KEY  = {KEY_W{1'b1}};
  localparam logic [COST_W-1:0] EMPTY_COST = {COST_W{1'b1}};

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef struct packed {
    logic [PARENT_W-1:0] parent;
    logic [COST_W-1:0]   cost;
    logic [BOARD_W-1:0]  board;
    logic [KEY_W-1:0]    key;
  } entry_t;

  typedef struct packed {
    logic insert;
    logic remove;
  } cell_ctl_t;

endpackage

[src/stable_sorted_priority_queue.sv]
// Top level of the stable sorted priority queue: cell chain, count and result register.
//
// Bounded min-priority queue of QUEUE_DEPTH entries, kept sorted by key in a
// chain of cells; equal keys leave in arrival order.
// Input channel s_axis: tuser carries the operation (insert or remove),
// tdata the key and the payload. Every beat yields exactly one result beat.
// Output channel m_axis: tuser carries found and overflow, tdata the popped
// entry and the occupancy after the beat.
// Throughput: one beat per cycle while the receiver does not stall. Each cell
// compares its key with the broadcast key and moves together, so the chain
// settles per beat. The result appears in the output register in the cycle
// after the input beat is taken.
// An insert into a full queue is dropped and flagged; a remove from an empty
// queue returns an all-ones key and cost with found low.
// Reset empties the queue and clears the output valid; output data is not reset.
// While the receiver stalls, the result is held and no new beat is taken;
// a new beat is taken in the same cycle as the held result leaves.
`include "assert_macros.svh"

module stable_sorted_priority_queue #(
  parameter int unsigned QUEUE_DEPTH = ssq_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // key, board, path_cost, parent_ref from bit 0 up, zero padded
  input  logic [ssq_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i,
  // op
  input  logic                             s_axis_tuser_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // out_key, out_board, out_path_cost, out_parent_ref, occupancy from bit 0 up
  output logic [ssq_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o,
  // found, overflow from bit 0 up
  output logic [ssq_pkg::OUT_TUSER_W-1:0]  m_axis_tuser_o
);
  import ssq_pkg::*;

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q, out_data_d;
  logic [OUT_TUSER_W-1:0] out_user_q, out_user_d;

  logic      in_acc, full, empty;
  cell_ctl_t ctl;
  entry_t    new_entry, res_entry;
  logic      found, overflow;
  logic [CNT_W+OCC_W-1:0] occ_wide;

  entry_t cell_entry [QUEUE_DEPTH];
  logic   cell_keep  [QUEUE_DEPTH];

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;
  assign full   = (count_q == FULL_CNT);
  assign empty  = (count_q == '0);

  assign new_entry = s_axis_tdata_i[ENTRY_W-1:0];

  assign ctl.insert = in_acc && (s_axis_tuser_i == OP_INSERT) && !full;
  assign ctl.remove = in_acc && (s_axis_tuser_i == OP_REMOVE) && !empty;

  for (genvar i = 0; i < int'(QUEUE_DEPTH); i++) begin : g_cell
    localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
    entry_t prev_entry, next_entry;
    logic   prev_keep;

    if (i == 0) begin : g_head
      assign prev_entry = new_entry;
      assign prev_keep  = 1'b1;
    end else begin : g_body
      assign prev_entry = cell_entry[i-1];
      assign prev_keep  = cell_keep[i-1];
    end

    if (i == int'(QUEUE_DEPTH) - 1) begin : g_tail
      assign next_entry = cell_entry[i];
    end else begin : g_inner
      assign next_entry = cell_entry[i+1];
    end

    ssq_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .occupied_i  (count_q > IDX),
      .new_i       (new_entry),
      .prev_i      (prev_entry),
      .prev_keep_i (prev_keep),
      .next_i      (next_entry),
      .entry_o     (cell_entry[i]),
      .keep_o      (cell_keep[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (ctl.insert) begin
      count_d = count_q + 1'b1;
    end else if (ctl.remove) begin
      count_d = count_q - 1'b1;
    end
  end

  always_comb begin
    res_entry = '0;
    found     = 1'b0;
    overflow  = 1'b0;
    if (s_axis_tuser_i == OP_REMOVE) begin
      if (empty) begin
        res_entry.key  = EMPTY_KEY;
        res_entry.cost = EMPTY_COST;
      end else begin
        res_entry = cell_entry[0];
        found     = 1'b1;
      end
    end else begin
      overflow = full;
    end
  end

  assign occ_wide   = {{OCC_W{1'b0}}, count_d};
  assign out_data_d = OUT_TDATA_W'({occ_wide[OCC_W-1:0], res_entry});
  assign out_user_d = {overflow, found};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_data_q <= out_data_d;
      out_user_q <= out_user_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

  `ASSERT_IMP(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= FULL_CNT,
              "entry count above queue depth")
  `ASSERT_IMP(a_head_sorted, clk_i, rst_ni, count_q >= CNT_W'(2),
              cell_entry[0].key <= cell_entry[1].key, "head cells out of order")
  `ASSERT_NXT(a_insert_count, clk_i, rst_ni, ctl.insert,
              count_q == $past(count_q) + 1'b1, "insert did not grow the queue")
  `ASSERT_NXT(a_remove_count, clk_i, rst_ni, ctl.remove,
              count_q == $past(count_q) - 1'b1, "remove did not shrink the queue")
  `ASSERT_IMP(a_overflow_full, clk_i, rst_ni, out_valid_q && out_user_q[1],
              count_q == FULL_CNT, "overflow flagged with room left")

endmodule

[src/ssq_cell.sv]
// One slot of the sorted chain: holds an entry, shifts down on insert, up on remove.
module ssq_cell (
  input  logic               clk_i,
  input  ssq_pkg::cell_ctl_t ctl_i,
  input  logic               occupied_i,
  input  ssq_pkg::entry_t    new_i,
  input  ssq_pkg::entry_t    prev_i,
  input  logic               prev_keep_i,
  input  ssq_pkg::entry_t    next_i,
  output ssq_pkg::entry_t    entry_o,
  output logic               keep_o
);
  import ssq_pkg::*;

  entry_t entry_q, entry_d;

  assign keep_o = occupied_i && (entry_q.key <= new_i.key);

  always_comb begin
    entry_d = entry_q;
    priority if (ctl_i.insert) begin
      priority if (keep_o) begin
        entry_d = entry_q;
      end else if (prev_keep_i) begin
        entry_d = new_i;
      end else begin
        entry_d = prev_i;
      end
    end else if (ctl_i.remove) begin
      entry_d = next_i;
    end else begin
      entry_d = entry_q;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule
